FILE: hw/rtl/mono_bitmap_pixel_expander_top_defines.svh
// Assertion macros shared by the expander RTL.
`ifndef MONO_BITMAP_PIXEL_EXPANDER_TOP_DEFINES_SVH
`define MONO_BITMAP_PIXEL_EXPANDER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define MBPE_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("mbpe: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define MBPE_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("mbpe: next-cycle check failed");
`else
`define MBPE_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons)
`define MBPE_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif

`endif

FILE: hw/rtl/mbpe_pkg.sv
package mbpe_pkg;

	// Fixed field widths
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
	localparam int COLOR_W       = 16;
	localparam int DIM_REG_W     = 11;
	localparam int ORIGIN_W      = 10;
	localparam int MODE_W        = 2;
	localparam int SCREEN_W      = 11;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOREGROUND,
		REG_BACKGROUND,
		REG_WIDTH,
		REG_HEIGHT,
		REG_MODE,
		REG_ORIGIN_X,
		REG_ORIGIN_Y
	} cfg_reg_t;

	// Pixel formats; other codes drop the byte
	typedef enum logic [MODE_W-1:0] {
		MODE_MONO,
		MODE_ALPHA
	} pixel_mode_t;

	// Configuration register contents
	typedef struct packed {
		logic [COLOR_W-1:0]   foreground_color;
		logic [COLOR_W-1:0]   background_color;
		logic [DIM_REG_W-1:0] image_width;
		logic [DIM_REG_W-1:0] image_height;
		logic [MODE_W-1:0]    pixel_mode;
		logic [ORIGIN_W-1:0]  origin_x;
		logic [ORIGIN_W-1:0]  origin_y;
	} cfg_t;

	// One pixel request from the sequencer to the color stage
	typedef struct packed {
		logic [7:0]           pixel_byte;
		logic [BIT_IDX_W-1:0] bit_idx;
		logic                 alpha;
		logic [SCREEN_W-1:0]  screen_x;
		logic [SCREEN_W-1:0]  screen_y;
		logic                 last_of_byte;
		logic                 row_end;
		logic                 image_end;
	} pix_req_t;

endpackage

FILE: hw/rtl/mbpe_byte_if.sv
interface mbpe_byte_if import mbpe_pkg::*; ;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink (input valid, input pixel_byte, output ready);
endinterface

FILE: hw/rtl/mbpe_pixel_if.sv
interface mbpe_pixel_if import mbpe_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [COLOR_W-1:0]  pixel_color;
	logic [SCREEN_W-1:0] screen_x;
	logic [SCREEN_W-1:0] screen_y;
	logic                last_of_byte;
	logic                row_end;
	logic                image_end;

	modport source (output valid, output pixel_color, output screen_x, output screen_y,
		output last_of_byte, output row_end, output image_end, input ready);
	modport sink (input valid, input pixel_color, input screen_x, input screen_y,
		input last_of_byte, input row_end, input image_end, output ready);
endinterface

FILE: hw/rtl/mbpe_cfg_if.sv
interface mbpe_cfg_if import mbpe_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mbpe_regs.sv
module mbpe_regs import mbpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mbpe_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	// Always take writes
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index and update one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.foreground_color <= '1;
			regs_q.background_color <= '0;
			regs_q.image_width      <= DIM_REG_W'(8);
			regs_q.image_height     <= DIM_REG_W'(8);
			regs_q.pixel_mode       <= MODE_MONO;
			regs_q.origin_x         <= '0;
			regs_q.origin_y         <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_FOREGROUND: regs_q.foreground_color <= cfg.data;
				REG_BACKGROUND: regs_q.background_color <= cfg.data;
				REG_WIDTH:      regs_q.image_width      <= cfg.data[DIM_REG_W-1:0];
				REG_HEIGHT:     regs_q.image_height     <= cfg.data[DIM_REG_W-1:0];
				REG_MODE:       regs_q.pixel_mode       <= cfg.data[MODE_W-1:0];
				REG_ORIGIN_X:   regs_q.origin_x         <= cfg.data[ORIGIN_W-1:0];
				REG_ORIGIN_Y:   regs_q.origin_y         <= cfg.data[ORIGIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/mbpe_seq.sv
`include "mono_bitmap_pixel_expander_top_defines.svh"

module mbpe_seq import mbpe_pkg::*; #(
	parameter int MAX_DIMENSION = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     regs,
	mbpe_byte_if.sink pix_in,
	output logic     req_valid,
	input  logic     req_ready,
	output pix_req_t req
);

	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam int DIM_W = CNT_W + 1;

	// Clamp a dimension register into 1..MAX_DIMENSION
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
		if (v == '0) return DIM_W'(1);
		else if (int'(v) > MAX_DIMENSION) return DIM_W'(MAX_DIMENSION);
		else return DIM_W'(v);
	endfunction

	logic [CNT_W-1:0]     col_q, row_q;
	logic                 valid_s1, alpha_s1;
	logic [7:0]           byte_s1;
	logic [BIT_IDX_W-1:0] idx_s1, last_s1;
	logic [CNT_W-1:0]     col_s1, row_s1;

	logic [DIM_W-1:0]     w, h, row_a, rem, col_end, row_b;
	logic                 col_wrap, in_fire, take, req_fire, done;
	logic [CNT_W-1:0]     col0, row0, col_nxt, row_nxt;
	logic [BIT_IDX_W-1:0] n_m1;

	assign w = clamp_dim(regs.image_width);
	assign h = clamp_dim(regs.image_height);

	// Start position of the arriving byte, and where the counters land after it
	always_comb begin
		col_wrap = {1'b0, col_q} >= w;
		col0     = col_wrap ? '0 : col_q;
		row_a    = col_wrap ? {1'b0, row_q} + DIM_W'(1) : {1'b0, row_q};
		row0     = (row_a >= h) ? '0 : row_a[CNT_W-1:0];
		rem      = w - {1'b0, col0};
		if (regs.pixel_mode == MODE_ALPHA) n_m1 = '0;
		else if (rem > DIM_W'(BITS_PER_BYTE)) n_m1 = BIT_IDX_W'(BITS_PER_BYTE - 1);
		else n_m1 = BIT_IDX_W'(rem - DIM_W'(1));
		col_end  = {1'b0, col0} + DIM_W'(n_m1) + DIM_W'(1);
		row_b    = {1'b0, row0} + DIM_W'(1);
		if (col_end >= w) begin
			col_nxt = '0;
			row_nxt = (row_b >= h) ? '0 : row_b[CNT_W-1:0];
		end else begin
			col_nxt = col_end[CNT_W-1:0];
			row_nxt = row0;
		end
	end

	// Handshake: a byte enters when the slot is free or frees this cycle
	assign req_fire     = req_valid && req_ready;
	assign done         = req_fire && (idx_s1 == last_s1);
	assign pix_in.ready = !valid_s1 || done;
	assign in_fire      = pix_in.valid && pix_in.ready;
	assign take         = in_fire && ((regs.pixel_mode == MODE_MONO) ||
		(regs.pixel_mode == MODE_ALPHA));

	// Hold counters and slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				col_q    <= col_nxt;
				row_q    <= row_nxt;
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Load a new byte, or advance one pixel within the current one
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= pix_in.pixel_byte;
			alpha_s1 <= (regs.pixel_mode == MODE_ALPHA);
			idx_s1   <= '0;
			last_s1  <= n_m1;
			col_s1   <= col0;
			row_s1   <= row0;
		end else if (req_fire && !done) begin
			idx_s1 <= idx_s1 + BIT_IDX_W'(1);
			col_s1 <= col_s1 + CNT_W'(1);
		end
	end

	// Build the pixel request for the current column
	always_comb begin
		req.pixel_byte   = byte_s1;
		req.bit_idx      = idx_s1;
		req.alpha        = alpha_s1;
		req.screen_x     = SCREEN_W'(regs.origin_x) + SCREEN_W'(col_s1);
		req.screen_y     = SCREEN_W'(regs.origin_y) + SCREEN_W'(row_s1);
		req.last_of_byte = (idx_s1 == last_s1);
		req.row_end      = ({1'b0, col_s1} + DIM_W'(1)) == w;
		req.image_end    = req.row_end && (({1'b0, row_s1} + DIM_W'(1)) == h);
	end
	assign req_valid = valid_s1;

	`MBPE_ASSERT_IMPL(a_idx_bound, clk, arst_n, valid_s1, idx_s1 <= last_s1)
	`MBPE_ASSERT_IMPL(a_alpha_single, clk, arst_n, valid_s1 && alpha_s1, last_s1 == '0)
	`MBPE_ASSERT_NEXT(a_hold_stalled, clk, arst_n, valid_s1 && !req_ready, valid_s1 && $stable(idx_s1) && $stable(col_s1))

endmodule

FILE: hw/rtl/mbpe_color.sv
`include "mono_bitmap_pixel_expander_top_defines.svh"

module mbpe_color import mbpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        regs,
	input  logic        req_valid,
	output logic        req_ready,
	input  pix_req_t    req,
	mbpe_pixel_if.source pix_out
);

	// Weighted mix of two 8-bit channel values
	function automatic logic [7:0] mix(input logic [7:0] bg, input logic [7:0] fg,
		input logic [7:0] a);
		logic [15:0] sum;
		sum = ({8'd0, bg} * {8'd0, a}) + ({8'd0, fg} * {8'd0, 8'd255 - a});
		return sum[15:8];
	endfunction

	logic               out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [SCREEN_W-1:0] x_q, y_q;
	logic               last_q, row_end_q, image_end_q;

	logic [COLOR_W-1:0] fg, bg, color;
	logic [7:0]         mix_r, mix_g, mix_b;

	assign fg = regs.foreground_color;
	assign bg = regs.background_color;

	// Pick the mono color or blend by alpha, then repack
	always_comb begin
		mix_r = mix({bg[4:0], 3'b011}, {fg[4:0], 3'b011}, req.pixel_byte);
		mix_g = mix({bg[10:5], 2'b01}, {fg[10:5], 2'b01}, req.pixel_byte);
		mix_b = mix({bg[15:11], 3'b011}, {fg[15:11], 3'b011}, req.pixel_byte);
		if (req.alpha) color = {mix_b[7:3], mix_g[7:2], mix_r[7:3]};
		else color = req.pixel_byte[req.bit_idx] ? fg : bg;
	end

	// Output register takes a pixel when empty or being drained
	assign req_ready = !out_valid_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_ready) begin
			out_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			color_q     <= color;
			x_q         <= req.screen_x;
			y_q         <= req.screen_y;
			last_q      <= req.last_of_byte;
			row_end_q   <= req.row_end;
			image_end_q <= req.image_end;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.pixel_color  = color_q;
	assign pix_out.screen_x     = x_q;
	assign pix_out.screen_y     = y_q;
	assign pix_out.last_of_byte = last_q;
	assign pix_out.row_end      = row_end_q;
	assign pix_out.image_end    = image_end_q;

	`MBPE_ASSERT_NEXT(a_req_lands, clk, arst_n, req_valid && req_ready, out_valid_q)

endmodule

FILE: hw/rtl/mono_bitmap_pixel_expander_top.sv
// Channel   Dir  Carries                                        Item moved when
// pix_in    in   pixel_byte                                     valid && ready
// pix_out   out  pixel_color, screen_x/y, last/row/image ends   valid && ready
// cfg       in   index, data (register write)                   valid && ready
//
// One pixel leaves per cycle while bytes arrive and the output is not stalled.
// A mono byte yields 1 to 8 pixels, an alpha byte one, each held in the byte
// slot until its last pixel is taken; pixels leave via the output register.
// Reset clears the counters and occupancy and loads the register defaults.
// A stalled output holds its pixel while the next one waits in the byte slot.
module mono_bitmap_pixel_expander_top import mbpe_pkg::*; #(
	parameter int MAX_DIMENSION = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	mbpe_cfg_if.sink     cfg,
	mbpe_byte_if.sink    pix_in,
	mbpe_pixel_if.source pix_out
);

	cfg_t     regs;
	pix_req_t req;
	logic     req_valid, req_ready;

	mbpe_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mbpe_seq #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.pix_in    (pix_in),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	mbpe_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pix_out   (pix_out)
	);

endmodule
